// ===== rtl/core/sorted_priority_queue_core_assert.svh =====
// ---------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Concurrent property wrappers, compiled out when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define SPQ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority queue: same-cycle check failed");

// Check that a condition implies another in the next cycle
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority queue: next-cycle check failed");

`else

`define SPQ_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes, fixed field widths and the cell control type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

   // Fixed field widths of the request and response channels
   localparam int KIND_BITS      = 3;
   localparam int INDEX_BITS     = 4;
   localparam int COUNT_OUT_BITS = 5;

   // Operation codes
   localparam logic [KIND_BITS-1:0] KIND_OFFER      = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_POLL       = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_READ_AT    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE_TAG = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE_AT  = 3'd4;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/spq_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: takes the new entry or its left neighbor on
// insert, takes its right neighbor on removal, holds otherwise.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
   parameter int CELL_INDEX   = 0,
   parameter int DEPTH        = 16,
   parameter int KEY_BITS     = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                          clock,
   input  cell_ctrl_type                 ctrl_i,
   input  logic [$clog2(DEPTH+1)-1:0]    count_i,
   input  logic [KEY_BITS-1:0]           new_key_i,
   input  logic [PAYLOAD_BITS-1:0]       new_tag_i,
   input  logic [$clog2(DEPTH)-1:0]      remove_pos_i,
   input  logic [KEY_BITS-1:0]           left_key_i,
   input  logic [PAYLOAD_BITS-1:0]       left_tag_i,
   input  logic                          left_after_i,
   input  logic [KEY_BITS-1:0]           right_key_i,
   input  logic [PAYLOAD_BITS-1:0]       right_tag_i,
   output logic [KEY_BITS-1:0]           key_o,
   output logic [PAYLOAD_BITS-1:0]       tag_o,
   output logic                          after_o,
   output logic                          insert_here_o,
   output logic                          match_o
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH+1);

   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] tag_ff, tag_in;
   logic                    occupied;
   logic                    shift_here;

   // Occupancy and local compares
   assign occupied      = CNT_BITS'(CELL_INDEX) < count_i;
   assign after_o       = !occupied || (key_ff > new_key_i);
   assign insert_here_o = after_o && !left_after_i;
   assign match_o       = occupied && (tag_ff == new_tag_i);
   assign shift_here    = PTR_BITS'(CELL_INDEX) >= remove_pos_i;

   // Pick the next contents of this slot
   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctrl_i.insert && after_o) begin
         key_in = left_after_i ? left_key_i : new_key_i;
         tag_in = left_after_i ? left_tag_i : new_tag_i;
      end else if (ctrl_i.remove && shift_here) begin
         key_in = right_key_i;
         tag_in = right_tag_i;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key_o = key_ff;
   assign tag_o = tag_ff;

endmodule

// ===== rtl/core/sorted_priority_queue_core.sv =====
// ---------------------------------------------------------------------------
// Sorted priority queue core
// Offer, poll, read-at, remove-by-tag and remove-at on a sorted cell chain.
// ---------------------------------------------------------------------------
// The queue lives in a chain of DEPTH cells kept in ascending key order, equal
// keys in arrival order. A transaction is accepted in the idle state and
// executed in the execute state once the response register is free. Remove
// by tag walks the chain from the tail, one cell per cycle. A finished
// result sits in the response register; the next request is accepted
// meanwhile, but the queue is not modified until that response is taken.
// Size and head on the response reflect the queue after the operation. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_assert.svh"

module sorted_priority_queue_core import spq_pkg::*; #(
   parameter int DEPTH        = 16,
   parameter int KEY_BITS     = 16,
   parameter int PAYLOAD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [KIND_BITS-1:0]      req_kind,
   input  logic [KEY_BITS-1:0]       req_priority_key,
   input  logic [PAYLOAD_BITS-1:0]   req_payload_tag,
   input  logic [INDEX_BITS-1:0]     req_position_index,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_ok,
   output logic [KEY_BITS-1:0]       rsp_result_key,
   output logic [PAYLOAD_BITS-1:0]   rsp_result_payload,
   output logic [INDEX_BITS-1:0]     rsp_insert_position,
   output logic [COUNT_OUT_BITS-1:0] rsp_removed_count,
   output logic [COUNT_OUT_BITS-1:0] rsp_queue_size,
   output logic                      rsp_head_valid,
   output logic [PAYLOAD_BITS-1:0]   rsp_head_payload
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH+1);
   localparam int CMP_BITS = (CNT_BITS > INDEX_BITS) ? CNT_BITS : INDEX_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   // Control state
   logic [1:0]              state_ff, state_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [PTR_BITS-1:0]     ptr_ff, ptr_in;
   logic [CNT_BITS-1:0]     rcount_ff, rcount_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Held request
   logic [KIND_BITS-1:0]    kind_ff;
   logic [KEY_BITS-1:0]     key_ff;
   logic [PAYLOAD_BITS-1:0] tag_ff;
   logic [INDEX_BITS-1:0]   idx_ff;

   // Response payload
   logic                    rsp_load;
   logic                    rsp_hold;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [KEY_BITS-1:0]     rsp_key_ff, rsp_key_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;
   logic [PTR_BITS-1:0]     rsp_ipos_ff, rsp_ipos_in;
   logic [CNT_BITS-1:0]     rsp_rcount_ff, rsp_rcount_in;

   // Chain wiring
   logic [KEY_BITS-1:0]     cell_key   [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_tag   [DEPTH];
   logic                    cell_after [DEPTH];
   logic                    cell_here  [DEPTH];
   logic                    cell_match [DEPTH];
   logic [KEY_BITS-1:0]     left_key   [DEPTH];
   logic [PAYLOAD_BITS-1:0] left_tag   [DEPTH];
   logic                    left_after [DEPTH];
   logic [KEY_BITS-1:0]     right_key  [DEPTH];
   logic [PAYLOAD_BITS-1:0] right_tag  [DEPTH];

   cell_ctrl_type           ctrl;
   logic                    adv;
   logic                    req_fire;
   logic [INDEX_BITS-1:0]   idx_eff;
   logic [CMP_BITS-1:0]     idx_wide;
   logic                    take_ok;
   logic [PTR_BITS-1:0]     sel_pos;
   logic [KEY_BITS-1:0]     sel_key;
   logic [PAYLOAD_BITS-1:0] sel_tag;
   logic [PTR_BITS-1:0]     ins_pos;
   logic [CNT_BITS-1:0]     rcount_hit;

   // Handshake
   assign rsp_hold  = rsp_valid_ff && !rsp_ready;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // Position select: poll always works on the head
   assign idx_eff  = (kind_ff == KIND_POLL) ? '0 : idx_ff;
   assign idx_wide = CMP_BITS'(idx_eff);
   assign take_ok  = idx_wide < CMP_BITS'(count_ff);
   assign sel_pos  = (state_ff == ST_SCAN) ? ptr_ff : idx_wide[PTR_BITS-1:0];
   assign sel_key  = cell_key[sel_pos];
   assign sel_tag  = cell_tag[sel_pos];

   // Encode the one-hot insertion point
   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (cell_here[i]) begin
            ins_pos = ins_pos | PTR_BITS'(i);
         end
      end
   end

   assign rcount_hit = rcount_ff + CNT_BITS'(cell_match[ptr_ff]);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      rcount_in     = rcount_ff;
      ctrl          = '0;
      rsp_load      = 1'b0;
      rsp_ok_in     = 1'b0;
      rsp_key_in    = '0;
      rsp_pay_in    = '0;
      rsp_ipos_in   = '0;
      rsp_rcount_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (adv) begin
               state_in = ST_IDLE;
               rsp_load = 1'b1;
               unique case (kind_ff) inside
                  KIND_OFFER: begin
                     if (count_ff != CNT_BITS'(DEPTH)) begin
                        ctrl.insert = 1'b1;
                        count_in    = count_ff + CNT_BITS'(1);
                        rsp_ok_in   = 1'b1;
                        rsp_ipos_in = ins_pos;
                     end
                  end
                  KIND_POLL, KIND_REMOVE_AT: begin
                     if (take_ok) begin
                        ctrl.remove = 1'b1;
                        count_in    = count_ff - CNT_BITS'(1);
                        rsp_ok_in   = 1'b1;
                        rsp_key_in  = sel_key;
                        rsp_pay_in  = sel_tag;
                     end
                  end
                  KIND_READ_AT: begin
                     if (take_ok) begin
                        rsp_ok_in  = 1'b1;
                        rsp_key_in = sel_key;
                        rsp_pay_in = sel_tag;
                     end
                  end
                  KIND_REMOVE_TAG: begin
                     if (count_ff != '0) begin
                        rsp_load  = 1'b0;
                        state_in  = ST_SCAN;
                        ptr_in    = PTR_BITS'(count_ff - CNT_BITS'(1));
                        rcount_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (adv) begin
               // drop the entry under the pointer if its tag matches
               if (cell_match[ptr_ff]) begin
                  ctrl.remove = 1'b1;
                  count_in    = count_ff - CNT_BITS'(1);
               end
               if (ptr_ff == '0) begin
                  state_in      = ST_IDLE;
                  rsp_load      = 1'b1;
                  rsp_ok_in     = (rcount_hit != '0);
                  rsp_rcount_in = rcount_hit;
               end else begin
                  ptr_in    = ptr_ff - PTR_BITS'(1);
                  rcount_in = rcount_hit;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || rsp_hold;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rcount_ff    <= rcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request and the response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff <= req_kind;
         key_ff  <= req_priority_key;
         tag_ff  <= req_payload_tag;
         idx_ff  <= req_position_index;
      end
      if (rsp_load) begin
         rsp_ok_ff     <= rsp_ok_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_pay_ff    <= rsp_pay_in;
         rsp_ipos_ff   <= rsp_ipos_in;
         rsp_rcount_ff <= rsp_rcount_in;
      end
   end

   // Cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_key[g]   = key_ff;
         assign left_tag[g]   = tag_ff;
         assign left_after[g] = 1'b0;
      end else begin : g_mid
         assign left_key[g]   = cell_key[g-1];
         assign left_tag[g]   = cell_tag[g-1];
         assign left_after[g] = cell_after[g-1];
      end
      if (g == DEPTH-1) begin : g_last
         assign right_key[g] = cell_key[g];
         assign right_tag[g] = cell_tag[g];
      end else begin : g_inner
         assign right_key[g] = cell_key[g+1];
         assign right_tag[g] = cell_tag[g+1];
      end

      spq_cell #(
         .CELL_INDEX   (g),
         .DEPTH        (DEPTH),
         .KEY_BITS     (KEY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock         (clock),
         .ctrl_i        (ctrl),
         .count_i       (count_ff),
         .new_key_i     (key_ff),
         .new_tag_i     (tag_ff),
         .remove_pos_i  (sel_pos),
         .left_key_i    (left_key[g]),
         .left_tag_i    (left_tag[g]),
         .left_after_i  (left_after[g]),
         .right_key_i   (right_key[g]),
         .right_tag_i   (right_tag[g]),
         .key_o         (cell_key[g]),
         .tag_o         (cell_tag[g]),
         .after_o       (cell_after[g]),
         .insert_here_o (cell_here[g]),
         .match_o       (cell_match[g])
      );
   end

   // Response outputs; size and head come straight from the held queue
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_result_key      = rsp_key_ff;
   assign rsp_result_payload  = rsp_pay_ff;
   assign rsp_insert_position = INDEX_BITS'(rsp_ipos_ff);
   assign rsp_removed_count   = COUNT_OUT_BITS'(rsp_rcount_ff);
   assign rsp_queue_size      = COUNT_OUT_BITS'(count_ff);
   assign rsp_head_valid      = (count_ff != '0);
   assign rsp_head_payload    = rsp_head_valid ? cell_tag[0] : '0;

   // Checks
   `SPQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_BITS'(DEPTH))
   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold, $stable(count_ff) && $stable(rsp_ok_ff))
   `SPQ_ASSERT_SAME(a_scan_in_range, clock, reset, state_ff == ST_SCAN, CNT_BITS'(ptr_ff) < count_ff)

endmodule
